// ----- rtl/pulse_peak_heart_rate_meter_core_defines.svh -----
// Assertion macros shared by the pulse peak heart rate meter RTL.
`ifndef PULSE_PEAK_HEART_RATE_METER_CORE_DEFINES_SVH
`define PULSE_PEAK_HEART_RATE_METER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PPHRM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("pphrm check failed");
`define PPHRM_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("pphrm reset check failed");
`else
`define PPHRM_ASSERT(lbl, prop)
`define PPHRM_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- rtl/pphrm_pkg.sv -----
// Types and constants of the pulse peak heart rate meter.
package pphrm_pkg;

	localparam int PEAK_DIVISOR = 2;
	localparam int SAMPLE_WIDTH = 16;
	localparam int SAMPLE_BITS  = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
	localparam logic [15:0] SAMPLE_MASK = 16'((32'h1 << SAMPLE_BITS) - 32'h1);

	localparam logic [10:0] IDX_QUARTER = 11'd250;
	localparam logic [10:0] IDX_HALF    = 11'd500;
	localparam logic [10:0] IDX_TWO_TH  = 11'd1000;
	localparam logic [10:0] IDX_FULL    = 11'd1500;

	localparam logic [3:0] MUL_QUARTER = 4'd12;
	localparam logic [3:0] MUL_HALF    = 4'd6;
	localparam logic [3:0] MUL_TWO_TH  = 4'd3;
	localparam logic [3:0] MUL_FULL    = 4'd2;

	localparam logic [14:0] RATE_MAX      = 15'd16383;
	localparam logic [15:0] MS_PER_SAMPLE = 16'(1000 / 50);
	localparam logic [15:0] LIMIT_RESET   = 16'd255;

	typedef struct packed {
		logic        pulse_seen;
		logic [15:0] beat_count;
		logic [15:0] rr_interval_ms;
		logic [13:0] heart_rate_bpm;
	} result_t;

	typedef struct packed {
		logic        wr;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

// ----- rtl/pphrm_core.sv -----
// Detector state and combinational update for one sample item.
module pphrm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  pphrm_pkg::cfg_wr_t  cfg,
	input  logic                step,
	input  logic                sample_valid,
	input  logic [15:0]         sample_value,
	output pphrm_pkg::result_t  result
);

	logic [15:0] limit_q;
	logic [15:0] peak_q;
	logic [15:0] thr_q;
	logic [10:0] win_q;
	logic [10:0] idx_q;
	logic [10:0] last_q;
	logic [15:0] beat_q;
	logic [13:0] rate_q;
	logic [15:0] intv_q;

	logic [15:0] sample;
	logic        raise;
	logic        pulse;
	logic [15:0] peak_d;
	logic [15:0] thr_d;
	logic [10:0] win_inc;
	logic [10:0] win_d;
	logic [10:0] idx_d;
	logic [10:0] last_d;
	logic [15:0] beat_d;
	logic [13:0] rate_d;
	logic [15:0] intv_d;
	logic [10:0] diff;
	logic [3:0]  mult;
	logic        rate_upd;
	logic [14:0] prod;

	always_comb begin
		sample  = sample_value & pphrm_pkg::SAMPLE_MASK;
		raise   = sample_valid && (peak_q < sample);
		pulse   = sample_valid && !raise && (sample < thr_q);
		diff    = idx_q - last_q;
		win_inc = pulse ? (win_q + 11'd1) : win_q;

		peak_d = peak_q;
		thr_d  = thr_q;
		last_d = last_q;
		beat_d = beat_q;
		intv_d = intv_q;
		if (raise) begin
			peak_d = sample;
			thr_d  = 16'(sample / pphrm_pkg::PEAK_DIVISOR);
		end else if (pulse) begin
			peak_d = '0;
			last_d = idx_q;
			beat_d = (beat_q >= limit_q) ? 16'd0 : (beat_q + 16'd1);
			intv_d = {5'd0, diff} * pphrm_pkg::MS_PER_SAMPLE;
		end

		rate_upd = 1'b1;
		case (idx_q)
			pphrm_pkg::IDX_QUARTER: mult = pphrm_pkg::MUL_QUARTER;
			pphrm_pkg::IDX_HALF:    mult = pphrm_pkg::MUL_HALF;
			pphrm_pkg::IDX_TWO_TH:  mult = pphrm_pkg::MUL_TWO_TH;
			pphrm_pkg::IDX_FULL:    mult = pphrm_pkg::MUL_FULL;
			default: begin
				mult     = 4'd0;
				rate_upd = 1'b0;
			end
		endcase
		prod = {4'd0, win_inc} * {11'd0, mult};

		rate_d = rate_q;
		win_d  = win_inc;
		if (!sample_valid) begin
			idx_d = '0;
		end else if (idx_q == pphrm_pkg::IDX_FULL) begin
			idx_d = '0;
			win_d = '0;
		end else begin
			idx_d = idx_q + 11'd1;
		end
		if (sample_valid && rate_upd) begin
			// saturate the window product at the rate field range
			rate_d = (prod > pphrm_pkg::RATE_MAX) ? pphrm_pkg::RATE_MAX[13:0] : prod[13:0];
		end

		result.heart_rate_bpm = rate_d;
		result.rr_interval_ms = intv_d;
		result.beat_count     = beat_d;
		result.pulse_seen     = pulse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pphrm_pkg::LIMIT_RESET;
			peak_q  <= '0;
			thr_q   <= '0;
			win_q   <= '0;
			idx_q   <= '0;
			last_q  <= '0;
			beat_q  <= '0;
			rate_q  <= '0;
			intv_q  <= '0;
		end else begin
			if (cfg.wr) begin
				limit_q <= cfg.data;
			end
			if (step) begin
				peak_q <= peak_d;
				thr_q  <= thr_d;
				win_q  <= win_d;
				idx_q  <= idx_d;
				last_q <= last_d;
				beat_q <= beat_d;
				rate_q <= rate_d;
				intv_q <= intv_d;
			end
		end
	end

endmodule

// ----- rtl/pphrm_out_buf.sv -----
// Two-entry result buffer between the update stage and the output channel.
module pphrm_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pphrm_pkg::result_t  push_data,
	output logic                has_room,
	output logic                out_valid,
	input  logic                out_ready,
	output pphrm_pkg::result_t  out_data
);

	pphrm_pkg::result_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign has_room  = (count_q != 2'd2);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/pulse_peak_heart_rate_meter_core.sv -----
// Top level of the pulse peak heart rate meter.
//
//  channel  dir  handshake                fields
//  s_*      in   s_tvalid / s_tready      tdata: sample_value, tuser: sample_valid
//  m_*      out  m_tvalid / m_tready      tdata: rate, rr interval, beat count; tuser: pulse
//  cfg_*    in   cfg_valid / cfg_ready    cfg_data: beat_count_limit
//
// One item per cycle sustained while the output accepts results.
// The item is held in an input register, then the detector update writes both the
// state and a two-entry result buffer in the same cycle.
// Reset clears the detector state and sets beat_count_limit to 255.
// A stalled output holds up to two results; input stalls only when both are taken.
`include "pulse_peak_heart_rate_meter_core_defines.svh"
module pulse_peak_heart_rate_meter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_value
	input  logic        s_tuser,   // [0] sample_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [13:0] heart_rate_bpm, [29:14] rr_interval_ms,
	                               // [45:30] beat_count, [47:46] zero
	output logic        m_tuser,   // [0] pulse_seen
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	logic        flag_s1;
	logic [15:0] value_s1;
	logic        go;
	logic        has_room;
	pphrm_pkg::cfg_wr_t cfg;
	pphrm_pkg::result_t result;
	pphrm_pkg::result_t out_res;

	assign cfg_ready = 1'b1;
	assign cfg.wr    = cfg_valid;
	assign cfg.data  = cfg_data;

	assign go       = valid_s1 && has_room;
	assign s_tready = !valid_s1 || has_room;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			flag_s1  <= s_tuser;
			value_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	pphrm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.step         (go),
		.sample_valid (flag_s1),
		.sample_value (value_s1),
		.result       (result)
	);

	pphrm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.push_data (result),
		.has_room  (has_room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {2'b00, out_res.beat_count, out_res.rr_interval_ms, out_res.heart_rate_bpm};
	assign m_tuser = out_res.pulse_seen;

	// a processed item must be visible on the output next cycle
	`PPHRM_ASSERT(a_go_shows_result, go |=> m_tvalid)
	// a blocked input means an item is parked in the input register
	`PPHRM_ASSERT(a_stall_has_item, !s_tready |-> valid_s1 && m_tvalid)
	// a parked item that cannot advance stays parked
	`PPHRM_ASSERT(a_park_holds, valid_s1 && !has_room |=> valid_s1)
	`PPHRM_ASSERT_RST(a_reset_empty, !arst_n |=> !m_tvalid && !valid_s1)

endmodule
